// ===== rtl/kmer_dictionary_hit_counter_unit_assert.svh =====
// assertion macros used by the k-mer hit counter controller
`ifndef KMER_DICTIONARY_HIT_COUNTER_UNIT_ASSERT_SVH
`define KMER_DICTIONARY_HIT_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define KDHC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("kdhc: same-cycle check failed");

// next-cycle implication, held off while in reset
`define KDHC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("kdhc: next-cycle check failed");

`endif

// ===== rtl/kdhc_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package kdhc_pkg;

  // parameter defaults
  localparam int KMER_LEN_DEF    = 16;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COUNT_BITS_DEF  = 32;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_PUSH   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOT_ASC = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // largest valid base code (T)
  localparam logic [2:0] BASE_T = 3'd3;

  // controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       clear_tab;
    logic       append;
    logic       push;
    logic       search_init;
    logic       probe_rd;
    logic       go_lo;
    logic       go_hi;
    logic       cnt_rd_idx;
    logic       cnt_rd_mid;
    logic       cnt_upd;
    logic       capture_rd;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       not_asc;
    logic       search_go;
    logic       idx_bad;
    logic       range_open;
    logic       key_eq;
    logic       key_lt;
  } sts_t;

endpackage

// ===== rtl/kdhc_ram.sv =====
// generic simple dual-port ram with registered read
module kdhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/kdhc_ctrl.sv =====
// sequencing state machine for the k-mer hit counter
`include "kmer_dictionary_hit_counter_unit_assert.svh"

module kdhc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  kdhc_pkg::sts_t  sts,
  output kdhc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PROBE,
    S_CMP,
    S_CRD,
    S_RDWAIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        case (sts.op)
          kdhc_pkg::CMD_CLEAR: begin
            cmd.clear_tab = 1'b1;
          end
          kdhc_pkg::CMD_APPEND: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = kdhc_pkg::ST_FULL;
            end else if (sts.not_asc) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = kdhc_pkg::ST_NOT_ASC;
            end else begin
              cmd.append = 1'b1;
            end
          end
          kdhc_pkg::CMD_PUSH: begin
            cmd.push = 1'b1;
            if (sts.search_go) begin
              cmd.search_init = 1'b1;
              state_nxt       = S_PROBE;
            end
          end
          default: begin
            if (sts.idx_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = kdhc_pkg::ST_RANGE;
            end else begin
              cmd.cnt_rd_idx = 1'b1;
              state_nxt      = S_RDWAIT;
            end
          end
        endcase
      end
      S_PROBE: begin
        if (sts.range_open) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = S_CMP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CMP: begin
        if (sts.key_eq) begin
          cmd.cnt_rd_mid = 1'b1;
          state_nxt      = S_CRD;
        end else if (sts.key_lt) begin
          cmd.go_lo = 1'b1;
          state_nxt = S_PROBE;
        end else begin
          cmd.go_hi = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_CRD: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = S_OUT;
      end
      S_RDWAIT: begin
        cmd.capture_rd = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `KDHC_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && !in_stall, state_r == S_DECODE)
  `KDHC_ASSERT_IMPLY(a_cmp_after_probe, clk, rst_n, state_r == S_CMP, $past(state_r) == S_PROBE)
  `KDHC_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_r || !out_stall)
  `KDHC_ASSERT_NEXT(a_out_after_load, clk, rst_n, cmd.load_out, out_valid_r && state_r == S_IDLE)

endmodule

// ===== rtl/kdhc_dp.sv =====
// datapath: window, dictionary and counter memories, search bounds, result registers
module kdhc_dp #(
  parameter int KMER_LEN    = kdhc_pkg::KMER_LEN_DEF,
  parameter int TABLE_DEPTH = kdhc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = kdhc_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kdhc_pkg::cmd_t cmd,
  output kdhc_pkg::sts_t sts,
  input  logic [1:0]     in_command,
  input  logic [2:0]     in_base_code,
  input  logic           in_read_start,
  input  logic [31:0]    in_entry_key,
  input  logic [11:0]    in_count_index,
  output logic [1:0]     out_status,
  output logic           out_match_found,
  output logic [11:0]    out_match_index,
  output logic [31:0]    out_count_value,
  output logic [12:0]    out_entry_total
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = AW + 1;
  localparam int WB = 2 * KMER_LEN;
  localparam int RW = $clog2(KMER_LEN + 1);

  // latched transaction
  logic [1:0]  op_r;
  logic [2:0]  base_r;
  logic        start_r;
  logic [31:0] key_r;
  logic [11:0] idx_r;

  // table and window state
  logic [LW-1:0] loaded_r;
  logic [31:0]   last_key_r;
  logic [WB-1:0] win_r, win_nxt;
  logic [RW-1:0] run_r, run_nxt;

  // search bounds
  logic [LW-1:0] lo_r, hi_r, mid;

  // staged result and output registers
  logic [1:0]            res_status_r;
  logic                  res_found_r;
  logic [AW-1:0]         res_index_r;
  logic [COUNT_BITS-1:0] res_count_r;
  logic [1:0]            out_status_r;
  logic                  out_found_r;
  logic [11:0]           out_index_r;
  logic [31:0]           out_count_r;

  // memory ports
  logic [31:0]           key_rdata;
  logic [COUNT_BITS-1:0] cnt_rdata, cnt_inc, cnt_wdata;
  logic [AW-1:0]         cnt_waddr, cnt_raddr;
  logic                  cnt_we, cnt_re;

  logic [WB-1:0] win_base;
  logic [RW-1:0] run_base;
  logic [63:0]   win_ext;
  logic [31:0]   idx_ext;
  logic          base_ok;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // window shift and clean-run count for a pushed base
  always_comb begin
    win_base = start_r ? '0 : win_r;
    run_base = start_r ? '0 : run_r;
    base_ok  = (base_r <= kdhc_pkg::BASE_T);
    win_ext  = (64'(win_base) << 2) | 64'(base_r[1:0]);
    if (base_ok) begin
      win_nxt = win_ext[WB-1:0];
      run_nxt = (run_base < RW'(KMER_LEN)) ? run_base + 1'b1 : run_base;
    end else begin
      win_nxt = win_base;
      run_nxt = '0;
    end
  end

  assign idx_ext = 32'(idx_r);
  assign cnt_inc = (cnt_rdata == {COUNT_BITS{1'b1}}) ? cnt_rdata : cnt_rdata + 1'b1;

  always_comb begin
    sts.op         = op_r;
    sts.full       = (loaded_r == LW'(TABLE_DEPTH));
    sts.not_asc    = (loaded_r != '0) && (key_r <= last_key_r);
    sts.search_go  = base_ok && (run_nxt == RW'(KMER_LEN));
    sts.idx_bad    = (idx_ext >= 32'(loaded_r)) || (idx_ext >= 32'(TABLE_DEPTH));
    sts.range_open = (lo_r < hi_r);
    sts.key_eq     = (64'(key_rdata) == 64'(win_r));
    sts.key_lt     = (64'(key_rdata) < 64'(win_r));
  end

  // counter memory: zeroed on append, read-modify-write on a hit
  assign cnt_we    = cmd.append | cmd.cnt_upd;
  assign cnt_waddr = cmd.cnt_upd ? mid[AW-1:0] : loaded_r[AW-1:0];
  assign cnt_wdata = cmd.cnt_upd ? cnt_inc : '0;
  assign cnt_re    = cmd.cnt_rd_idx | cmd.cnt_rd_mid;
  assign cnt_raddr = cmd.cnt_rd_mid ? mid[AW-1:0] : idx_ext[AW-1:0];

  kdhc_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (loaded_r[AW-1:0]),
    .wdata (key_r),
    .re    (cmd.probe_rd),
    .raddr (mid[AW-1:0]),
    .rdata (key_rdata)
  );

  kdhc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      win_r    <= '0;
      run_r    <= '0;
    end else begin
      if (cmd.clear_tab) begin
        loaded_r <= '0;
      end else if (cmd.append) begin
        loaded_r <= loaded_r + 1'b1;
      end
      if (cmd.push) begin
        win_r <= win_nxt;
        run_r <= run_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r         <= in_command;
      base_r       <= in_base_code;
      start_r      <= in_read_start;
      key_r        <= in_entry_key;
      idx_r        <= in_count_index;
      res_status_r <= kdhc_pkg::ST_OK;
      res_found_r  <= 1'b0;
      res_index_r  <= '0;
      res_count_r  <= '0;
    end
    if (cmd.append) begin
      last_key_r <= key_r;
    end
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= loaded_r;
    end else if (cmd.go_lo) begin
      lo_r <= mid + 1'b1;
    end else if (cmd.go_hi) begin
      hi_r <= mid;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
    end
    if (cmd.cnt_upd) begin
      res_found_r <= 1'b1;
      res_index_r <= mid[AW-1:0];
      res_count_r <= cnt_inc;
    end
    if (cmd.capture_rd) begin
      res_count_r <= cnt_rdata;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_index_r  <= 12'(32'(res_index_r));
      out_count_r  <= 32'(64'(res_count_r));
    end
  end

  logic [12:0] total_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      total_r <= 13'(32'(loaded_r));
    end
  end

  assign out_status      = out_status_r;
  assign out_match_found = out_found_r;
  assign out_match_index = out_index_r;
  assign out_count_value = out_count_r;
  assign out_entry_total = total_r;

endmodule

// ===== rtl/kmer_dictionary_hit_counter_unit.sv =====
// top level of the k-mer dictionary hit counter
// usage:
//  - one input channel (in_valid / in_stall) carries a command per transaction:
//    clear the table, append a dictionary key, push a read base, or read a counter
//  - every input transaction yields exactly one result transaction on
//    out_valid / out_stall, in order
//  - dictionary keys must be appended in strictly ascending order
//  - a pushed base completing KMER_LEN clean bases starts a binary search of the
//    loaded keys; a hit does a saturating read-modify-write of its counter
//  - clear, append, rejected commands and pushes without a search go from
//    decode straight to output; a counter read first waits for the counter memory
//  - a search alternates probe and compare states, then updates the counter on a hit;
//    probes number up to ceil(log2(entries + 1)), about 13 at 4096 entries,
//    each probe waiting on the registered read of the key memory
//  - one transaction is in progress at a time; the next is accepted once the
//    finished result sits in the output register
//  - if the receiver stalls, the result holds steady and the block waits
//    before loading the next result
//  - reset empties the table and the read window; memories are not cleared
module kmer_dictionary_hit_counter_unit #(
  parameter int KMER_LEN    = kdhc_pkg::KMER_LEN_DEF,
  parameter int TABLE_DEPTH = kdhc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = kdhc_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_base_code,
  input  logic        in_read_start,
  input  logic [31:0] in_entry_key,
  input  logic [11:0] in_count_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_match_found,
  output logic [11:0] out_match_index,
  output logic [31:0] out_count_value,
  output logic [12:0] out_entry_total
);

  // command and status buses between sequencer and datapath
  kdhc_pkg::cmd_t cmd;
  kdhc_pkg::sts_t sts;

  // sequencer: accepts a transaction, steps the search and owns out_valid
  kdhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: window, key and counter memories, result registers
  kdhc_dp #(
    .KMER_LEN    (KMER_LEN),
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_base_code    (in_base_code),
    .in_read_start   (in_read_start),
    .in_entry_key    (in_entry_key),
    .in_count_index  (in_count_index),
    .out_status      (out_status),
    .out_match_found (out_match_found),
    .out_match_index (out_match_index),
    .out_count_value (out_count_value),
    .out_entry_total (out_entry_total)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the k-mer dictionary hit counter
module tb_top;
  import kdhc_pkg::*;

  localparam int KMER_LEN     = KMER_LEN_DEF;
  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int FILL_KEYS    = 600;
  localparam int RANDOM_ITEMS = 850;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_REPORTS  = 200;

  // base codes; anything above BASE_T counts as a non-ACGT character
  localparam logic [2:0] BASE_A   = 3'd0;
  localparam logic [2:0] BASE_OTH = 3'd4;
  localparam logic [2:0] BASE_TOP = 3'd7;

  // one input transaction, plus a flag that holds the sender until all results are in
  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  base_code;
    logic        read_start;
    logic [31:0] entry_key;
    logic [11:0] count_index;
    bit          drain;
  } kmer_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        match_found;
    logic [11:0] match_index;
    logic [31:0] count_value;
    logic [12:0] entry_total;
  } hit_result_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command    = CMD_CLEAR;
  logic [2:0]  in_base_code  = BASE_A;
  logic        in_read_start = 1'b0;
  logic [31:0] in_entry_key  = '0;
  logic [11:0] in_count_index = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [1:0]  out_status;
  logic        out_match_found;
  logic [11:0] out_match_index;
  logic [31:0] out_count_value;
  logic [12:0] out_entry_total;

  int cyc          = 0;
  int error_count  = 0;
  int accepted_cnt = 0;
  int total_items  = 0;

  kmer_cmd_t   cmd_backlog[$];   // transactions waiting to be driven
  kmer_cmd_t   cur_cmd;          // transaction currently on the input ports
  hit_result_t due_results[$];   // predicted results, oldest first

  // shadow copy of the dictionary, counters and read window
  bit [31:0]            dict_keys [TABLE_DEPTH];
  bit [31:0]            hit_counts[TABLE_DEPTH];
  int                   n_loaded  = 0;
  bit [2*KMER_LEN-1:0]  window    = '0;
  int                   clean_run = 0;

  kmer_dictionary_hit_counter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_base_code   (in_base_code),
    .in_read_start  (in_read_start),
    .in_entry_key   (in_entry_key),
    .in_count_index (in_count_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_match_found(out_match_found),
    .out_match_index(out_match_index),
    .out_count_value(out_count_value),
    .out_entry_total(out_entry_total)
  );

  always #1 clk = ~clk;

  // cycle count, reset release and the timeout guard
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == RESET_CYCLES - 1) rst_n <= 1'b1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $realtime, cyc,
               due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // random idling on both sides, about 15 percent of the time,
  // with one quiet stretch out of every four windows
  function automatic bit take_break();
    if ((cyc / 5000) % 4 == 3) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  // binary search over the loaded keys, -1 when the key is absent
  function automatic int find_key(bit [31:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n_loaded;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (dict_keys[mid] == key) return mid;
      if (dict_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return -1;
  endfunction

  // advance the shadow state by one transaction and return the result it should give
  function automatic hit_result_t predict_hit_result(kmer_cmd_t c);
    hit_result_t r;
    int slot;
    r = '0;
    case (c.command)
      CMD_CLEAR: begin
        // the read window survives a clear
        n_loaded = 0;
      end
      CMD_APPEND: begin
        if (n_loaded >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (n_loaded > 0 && c.entry_key <= dict_keys[n_loaded-1]) begin
          r.status = ST_NOT_ASC;
        end else begin
          dict_keys[n_loaded]  = c.entry_key;
          hit_counts[n_loaded] = '0;
          n_loaded++;
        end
      end
      CMD_PUSH: begin
        if (c.read_start) begin
          window    = '0;
          clean_run = 0;
        end
        if (c.base_code > BASE_T) begin
          clean_run = 0;
        end else begin
          window = {window[2*KMER_LEN-3:0], c.base_code[1:0]};
          if (clean_run < KMER_LEN) clean_run++;
          if (clean_run >= KMER_LEN) begin
            slot = find_key(window);
            if (slot >= 0) begin
              // counters saturate at all ones
              if (hit_counts[slot] != '1) hit_counts[slot]++;
              r.match_found = 1'b1;
              r.match_index = slot[11:0];
              r.count_value = hit_counts[slot];
            end
          end
        end
      end
      default: begin
        if (c.count_index >= n_loaded) r.status = ST_RANGE;
        else r.count_value = hit_counts[c.count_index];
      end
    endcase
    r.entry_total = n_loaded[12:0];
    return r;
  endfunction

  // input driver: holds the payload while stalled, predicts on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_hit_result(cur_cmd));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() == 0 || take_break() ||
            (cmd_backlog[0].drain && due_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_cmd        = cmd_backlog.pop_front();
          in_valid       <= 1'b1;
          in_command     <= cur_cmd.command;
          in_base_code   <= cur_cmd.base_code;
          in_read_start  <= cur_cmd.read_start;
          in_entry_key   <= cur_cmd.entry_key;
          in_count_index <= cur_cmd.count_index;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      // keep the log bounded if the block goes badly wrong
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    end
  endfunction

  // result monitor and receiver stalls
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= take_break();
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, expected none, actual status %0h",
                   $realtime, out_status);
        end else begin
          want = due_results.pop_front();
          check_field("status",      want.status,      out_status);
          check_field("match_found", want.match_found, out_match_found);
          check_field("match_index", want.match_index, out_match_index);
          check_field("count_value", want.count_value, out_count_value);
          check_field("entry_total", want.entry_total, out_entry_total);
        end
      end
    end
  end

  // fields a command does not use carry random values
  function automatic kmer_cmd_t rand_cmd(logic [1:0] c);
    kmer_cmd_t t;
    t.command     = c;
    t.base_code   = 3'($urandom);
    t.read_start  = 1'($urandom);
    t.entry_key   = $urandom;
    t.count_index = 12'($urandom);
    t.drain       = 1'b0;
    return t;
  endfunction

  task automatic queue_clear(bit hold);
    kmer_cmd_t t;
    t = rand_cmd(CMD_CLEAR);
    t.drain = hold;
    cmd_backlog.push_back(t);
  endtask

  task automatic queue_append(logic [31:0] key);
    kmer_cmd_t t;
    t = rand_cmd(CMD_APPEND);
    t.entry_key = key;
    cmd_backlog.push_back(t);
  endtask

  task automatic queue_push(logic [2:0] base, logic fresh);
    kmer_cmd_t t;
    t = rand_cmd(CMD_PUSH);
    t.base_code  = base;
    t.read_start = fresh;
    cmd_backlog.push_back(t);
  endtask

  task automatic queue_read(logic [11:0] idx);
    kmer_cmd_t t;
    t = rand_cmd(CMD_READ);
    t.count_index = idx;
    cmd_backlog.push_back(t);
  endtask

  // the bases of one k-mer, first base first, so the window ends up equal to the key
  task automatic queue_key_bases(logic [31:0] key, logic fresh);
    for (int j = 0; j < KMER_LEN; j++)
      queue_push({1'b0, key[2*KMER_LEN-1-2*j -: 2]}, fresh && j == 0);
  endtask

  initial begin : stimulus
    bit [31:0]   key_list[$];
    longint      next_key;
    longint      gap;
    int          n_keys;
    int          n_ops;
    int          sel;
    int          len;
    int          base_sz;
    int          phase;

    // directed: empty table, bad bases, key extremes, rejected appends
    queue_read(12'd0);
    queue_push(BASE_TOP, 1'b1);
    queue_append(32'h0000_0000);
    queue_append(32'hFFFF_FFFF);
    queue_append(32'hFFFF_FFFF);        // duplicate key
    queue_append(32'h1234_5678);        // smaller than the last key
    queue_key_bases(32'h0000_0000, 1'b1);  // window of all A hits entry 0
    queue_push(BASE_T, 1'b0);           // slides to a window that is absent
    queue_read(12'd0);
    queue_read(12'd1);
    queue_read(12'd2);                  // equal to the entry count
    queue_read(12'hFFF);
    queue_clear(1'b0);
    queue_read(12'd0);
    queue_append(32'h0000_0005);        // ascending check starts over after a clear
    queue_push(BASE_OTH, 1'b0);

    // load a large table, top up with the largest key, then search its ends
    queue_clear(1'b1);
    key_list.delete();
    for (int i = 0; i < FILL_KEYS; i++) begin
      key_list.push_back({i[11:0], 20'(($urandom))});
      queue_append(key_list[i]);
    end
    queue_append(32'hFFFF_FFFF);
    queue_append($urandom);
    queue_key_bases(key_list[0], 1'b1);
    queue_key_bases(key_list[FILL_KEYS-1], 1'b1);
    for (int i = 0; i < 6; i++) queue_key_bases(key_list[$urandom_range(0, FILL_KEYS-1)], 1'b0);
    queue_read(12'd0);
    queue_read(12'hFFF);
    for (int i = 0; i < 4; i++) queue_read(12'($urandom));

    // random phases: a fresh dictionary, then reads drawn mostly from its keys
    base_sz = cmd_backlog.size();
    phase   = 0;
    while (cmd_backlog.size() - base_sz < RANDOM_ITEMS) begin
      queue_clear(phase % 3 == 0);
      phase++;
      n_keys = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
      gap = 64'hFFFF_FFFF / (n_keys + 1);
      next_key = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 32'(gap));
      key_list.delete();
      for (int i = 0; i < n_keys; i++) begin
        key_list.push_back(32'(next_key));
        next_key += 1 + $urandom_range(0, 32'(gap - 1));
      end
      if ($urandom_range(0, 7) == 0) key_list[n_keys-1] = 32'hFFFF_FFFF;
      for (int i = 0; i < n_keys; i++) begin
        // now and then re-send an earlier key, which must be refused
        if (i > 0 && $urandom_range(0, 9) == 0) queue_append(key_list[$urandom_range(0, i-1)]);
        queue_append(key_list[i]);
      end

      n_ops = $urandom_range(3, 10);
      for (int op = 0; op < n_ops; op++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          // well-formed read: short random lead-in, then whole k-mers from the dictionary
          len = $urandom_range(0, 4);
          for (int j = 0; j < len; j++) queue_push(3'($urandom_range(0, 3)), j == 0);
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++)
            queue_key_bases(key_list[$urandom_range(0, key_list.size()-1)],
                            j == 0 && cmd_backlog[$].command != CMD_PUSH);
        end else if (sel < 75) begin
          // noisy read: random bases, some non-ACGT, stray read starts
          len = $urandom_range(5, 40);
          for (int j = 0; j < len; j++)
            queue_push(($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                   : 3'($urandom_range(0, 3)),
                       $urandom_range(0, 9) == 0);
        end else if (sel < 80) begin
          // broken read: a whole k-mer, then a new read cuts in
          queue_key_bases(key_list[$urandom_range(0, key_list.size()-1)], 1'b1);
          queue_push(3'($urandom_range(0, 3)), 1'b1);
        end else if (sel < 92) begin
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++)
            queue_read(($urandom_range(0, 4) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(0, key_list.size()-1)));
        end else if (key_list[$] < 32'hFFFF_0000) begin
          // late append, still ascending
          key_list.push_back(key_list[$] + 1 + $urandom_range(0, 4095));
          queue_append(key_list[$]);
        end else begin
          queue_append(key_list[$]);
        end
      end
    end

    total_items = cmd_backlog.size();
    while (accepted_cnt != total_items) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kdhc_pkg.sv
rtl/kdhc_ram.sv
rtl/kdhc_ctrl.sv
rtl/kdhc_dp.sv
rtl/kmer_dictionary_hit_counter_unit.sv
tb/tb_top.sv
